// ===== rtl/idq_pkg.sv =====
// ----------------------------------------------------------------------------
// idq_pkg
// Shared types, constants and helpers of the indexed double-ended queue.
// ----------------------------------------------------------------------------
package idq_pkg;

   // Store geometry.
   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_WIDTH = $clog2(CAPACITY);
   localparam int CNT_WIDTH  = $clog2(CAPACITY + 1);

   // Action codes carried in the request.
   typedef enum logic [2:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_BACK   = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_READ       = 3'd4,
      ACT_WRITE      = 3'd5
   } action_type;

   // Status codes returned in the response.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // One request beat.
   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] value;
      logic [5:0]         position;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [6:0]         element_count;
   } rsp_type;

   // Sequencing commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic reply;
   } cmd_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_EXEC  = 2'd1,
      S_REPLY = 2'd2
   } state_type;

   // Sign-extend a 32-bit input value and cut it to the store width.
   function automatic logic [DATA_WIDTH-1:0] widen_value(input logic signed [31:0] raw);
      logic signed [63:0] ext;
      ext = 64'(raw);
      return ext[DATA_WIDTH-1:0];
   endfunction

   // Sign-extend a stored element and cut it to the 32-bit result.
   function automatic logic signed [31:0] narrow_value(input logic [DATA_WIDTH-1:0] stored);
      logic signed [63:0] ext;
      ext = 64'(signed'(stored));
      return ext[31:0];
   endfunction

endpackage

// ===== rtl/indexed_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// indexed_double_ended_queue
// Double-ended queue of signed values in a ring buffer with read and write
// by index from the front.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. Each request
// goes through capture, execute with one store access, and respond, and the
// next one can be taken in the cycle after the response; the sequence is
// set by the single-port store access and its registered read. Every request
// gives exactly one response beat, shown for one cycle with rsp_valid high;
// the receiver must take it then, it cannot stall the block. The response
// carries the read value (zero unless a read succeeded), a status and the
// element count after the action. The store needs no clearing after reset.
module indexed_double_ended_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  idq_pkg::req_type req_item,
   output logic             rsp_valid,
   output idq_pkg::rsp_type rsp_item
);
   import idq_pkg::*;

   cmd_type cmd;

   idq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   idq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

   assign rsp_valid = cmd.reply;

   // An accepted request makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a request");

   // A response is never longer than one beat.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response held for more than one cycle");

   // The element count never exceeds the store size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_item.element_count) <= CAPACITY))
      else $error("element count beyond capacity");

   // Empty status only with no elements, full status only with a full store.
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_EMPTY) |-> (rsp_item.element_count == 7'd0))
      else $error("empty status with elements held");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_FULL) |->
         (32'(rsp_item.element_count) == CAPACITY))
      else $error("full status with free entries");

endmodule

// ===== rtl/idq_ctrl.sv =====
// ----------------------------------------------------------------------------
// idq_ctrl
// Sequencer: takes a request, lets the datapath execute it, then presents
// the response beat for one cycle.
// ----------------------------------------------------------------------------
module idq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output idq_pkg::cmd_type cmd
);
   import idq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      cmd.reply = 1'b0;
      busy      = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_REPLY;
         end
         S_REPLY: begin
            cmd.reply = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/idq_datapath.sv =====
// ----------------------------------------------------------------------------
// idq_datapath
// Ring-buffer store with front pointer and element count; executes one
// action per exec command and builds the response.
// ----------------------------------------------------------------------------
module idq_datapath (
   input  logic             clock,
   input  logic             reset,
   input  idq_pkg::cmd_type cmd,
   input  idq_pkg::req_type req_item,
   output idq_pkg::rsp_type rsp_item
);
   import idq_pkg::*;

   logic [DATA_WIDTH-1:0] store_mem [CAPACITY];

   req_type               req_ff;
   logic [ADDR_WIDTH-1:0] front_ff;
   logic [ADDR_WIDTH-1:0] front_in;
   logic [CNT_WIDTH-1:0]  count_ff;
   logic [CNT_WIDTH-1:0]  count_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  rd_ok_ff;
   logic                  rd_ok_in;
   status_type            status_ff;
   status_type            status_in;

   logic                  is_full;
   logic                  is_empty;
   logic                  out_of_range;
   logic [ADDR_WIDTH-1:0] offset;
   logic [ADDR_WIDTH:0]   slot_sum;
   logic [ADDR_WIDTH-1:0] slot;
   logic                  wr_en;

   // Capture the request beat.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
   end

   assign is_full      = (count_ff == CNT_WIDTH'(CAPACITY));
   assign is_empty     = (count_ff == '0);
   assign out_of_range = (32'(req_ff.position) >= 32'(count_ff));

   // Offset from the front that the action addresses.
   always_comb begin
      unique case (req_ff.action)
         ACT_PUSH_BACK:  offset = count_ff[ADDR_WIDTH-1:0];
         ACT_PUSH_FRONT: offset = ADDR_WIDTH'(CAPACITY - 1);
         ACT_POP_FRONT:  offset = ADDR_WIDTH'(1);
         default:        offset = ADDR_WIDTH'(req_ff.position);
      endcase
   end

   // Slot = (front + offset) wrapped around the store.
   assign slot_sum = {1'b0, front_ff} + {1'b0, offset};
   assign slot     = (32'(slot_sum) >= CAPACITY) ?
                     ADDR_WIDTH'(32'(slot_sum) - CAPACITY) : slot_sum[ADDR_WIDTH-1:0];

   // Action decode: pointer, count, status and store write.
   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      rd_ok_in  = 1'b0;
      wr_en     = 1'b0;
      unique case (req_ff.action)
         ACT_PUSH_BACK: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_WIDTH'(1);
            end
         end
         ACT_PUSH_FRONT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               front_in = slot;
               count_in = count_ff + CNT_WIDTH'(1);
            end
         end
         ACT_POP_BACK: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_WIDTH'(1);
            end
         end
         ACT_POP_FRONT: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               front_in = slot;
               count_in = count_ff - CNT_WIDTH'(1);
            end
         end
         ACT_READ: begin
            if (out_of_range) begin
               status_in = ST_RANGE;
            end else begin
               rd_ok_in = 1'b1;
            end
         end
         ACT_WRITE: begin
            if (out_of_range) begin
               status_in = ST_RANGE;
            end else begin
               wr_en = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Element store: at most one write and one registered read per exec cycle.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (wr_en) begin
            store_mem[slot] <= widen_value(req_ff.value);
         end
         rd_data_ff <= store_mem[slot];
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         rd_ok_ff  <= rd_ok_in;
      end
   end

   // Queue control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   // Response beat.
   assign rsp_item.read_value    = rd_ok_ff ? narrow_value(rd_data_ff) : 32'sd0;
   assign rsp_item.status        = status_ff;
   assign rsp_item.element_count = 7'(count_ff);

endmodule

// ===== verif/tb_indexed_double_ended_queue.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_double_ended_queue
// Self-checking bench for the indexed double-ended queue. A mirror of the
// ring buffer predicts each response beat from the accepted request beats.
// A short directed pass hits the corner cases. Random fill, drain and mixed
// phases then push the queue to full and to empty, with both ends and
// indexed access, while start idles at random.
// ----------------------------------------------------------------------------
module tb_indexed_double_ended_queue;
   import idq_pkg::*;

   // Action codes that the block treats as no operation.
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int PHASE_BEATS    = 150;

   // Traffic shape of one random phase.
   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_mode;

   // Mirror of the ring buffer with the queue of responses still owed.
   class deque_mirror;
      logic [DATA_WIDTH-1:0] slots[CAPACITY];
      int                    head;
      int                    fill;
      int                    peak_fill;
      int                    errors;
      int                    status_tally[4];
      rsp_type               owed_replies[$];

      function new();
         head      = 0;
         fill      = 0;
         peak_fill = 0;
         errors    = 0;
         foreach (status_tally[i]) status_tally[i] = 0;
      endfunction

      function int fill_level();
         return fill;
      endfunction

      function int pending_count();
         return owed_replies.size();
      endfunction

      task report_mismatch(input string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Apply one accepted request beat and queue the response it owes.
      function void note_request(input req_type r);
         rsp_type owed;
         owed        = '0;
         owed.status = ST_OK;
         case (r.action)
            ACT_PUSH_BACK: begin
               if (fill == CAPACITY) begin
                  owed.status = ST_FULL;
               end else begin
                  slots[(head + fill) % CAPACITY] = DATA_WIDTH'(r.value);
                  fill++;
               end
            end
            ACT_PUSH_FRONT: begin
               if (fill == CAPACITY) begin
                  owed.status = ST_FULL;
               end else begin
                  head        = (head + CAPACITY - 1) % CAPACITY;
                  slots[head] = DATA_WIDTH'(r.value);
                  fill++;
               end
            end
            ACT_POP_BACK: begin
               if (fill == 0) owed.status = ST_EMPTY;
               else fill--;
            end
            ACT_POP_FRONT: begin
               if (fill == 0) begin
                  owed.status = ST_EMPTY;
               end else begin
                  head = (head + 1) % CAPACITY;
                  fill--;
               end
            end
            ACT_READ: begin
               if (int'(r.position) >= fill) begin
                  owed.status = ST_RANGE;
               end else begin
                  owed.read_value =
                     32'(signed'(slots[(head + int'(r.position)) % CAPACITY]));
               end
            end
            ACT_WRITE: begin
               if (int'(r.position) >= fill) owed.status = ST_RANGE;
               else slots[(head + int'(r.position)) % CAPACITY] = DATA_WIDTH'(r.value);
            end
            default: begin
            end
         endcase
         owed.element_count = 7'(fill);
         if (fill > peak_fill) peak_fill = fill;
         owed_replies = {owed_replies, owed};
      endfunction

      // Compare one response beat with the oldest owed response.
      task check_response(input rsp_type got);
         rsp_type owed;
         status_tally[got.status]++;
         if (owed_replies.size() == 0) begin
            report_mismatch($sformatf("response beat with none owed: %p", got));
         end else begin
            owed = owed_replies[0];
            owed_replies.delete(0);
            if (got.read_value !== owed.read_value)
               report_mismatch($sformatf("read_value %0d, predicted %0d",
                                         got.read_value, owed.read_value));
            if (got.status !== owed.status)
               report_mismatch($sformatf("status %0d, predicted %0d",
                                         got.status, owed.status));
            if (got.element_count !== owed.element_count)
               report_mismatch($sformatf("element_count %0d, predicted %0d",
                                         got.element_count, owed.element_count));
         end
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   deque_mirror dq = new();
   int          cycle_count = 0;
   int          beats_sent  = 0;
   bit          idle_on     = 1'b1;

   indexed_double_ended_queue uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Cycle counter and the run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= TIMEOUT_CYCLES);
      $display("Timeout after %0d cycles, %0d responses still owed",
               cycle_count, dq.pending_count());
      $display("Regression FAIL");
      $finish;
   end

   // Watch both channels with the values held before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) dq.note_request(req_item);
         if (rsp_valid) dq.check_response(rsp_item);
      end
   end

   function automatic req_type make_req(input logic [2:0] act, input logic signed [31:0] val,
                                        input logic [5:0] pos);
      req_type r;
      r.action   = act;
      r.value    = val;
      r.position = pos;
      return r;
   endfunction

   // Offer one request beat, after a random idle gap, and hold it until taken.
   // Start stays high when no gap follows, so it is never lowered and raised
   // in the same step.
   task automatic send_request(input req_type item);
      int gap;
      gap = 0;
      if (idle_on) begin
         while ($urandom_range(0, 99) < 30) gap++;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      beats_sent++;
   endtask

   // Stimulus and end of run.
   initial begin
      mix_mode                plan[7];
      int                     roll;
      int                     depth;
      logic [2:0]             act;
      logic signed [31:0]     val;
      logic [5:0]             pos;

      plan = '{MODE_FILL, MODE_MIX, MODE_DRAIN, MODE_MIX, MODE_FILL, MODE_DRAIN,
               MODE_MIX};
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed pass: empty list, spare codes, extreme values, both ends.
      send_request(make_req(ACT_POP_BACK, 32'sd0, 6'd0));
      send_request(make_req(ACT_POP_FRONT, -32'sd1, 6'd63));
      send_request(make_req(ACT_READ, 32'sd0, 6'd0));
      send_request(make_req(ACT_WRITE, 32'sd5, 6'd63));
      send_request(make_req(ACT_SPARE_6, -32'sd1, 6'd63));
      send_request(make_req(ACT_SPARE_7, 32'sd0, 6'd0));
      send_request(make_req(ACT_PUSH_BACK, 32'h7FFF_FFFF, 6'd0));
      send_request(make_req(ACT_PUSH_FRONT, 32'h8000_0000, 6'd63));
      send_request(make_req(ACT_PUSH_BACK, -32'sd1, 6'd0));
      send_request(make_req(ACT_PUSH_FRONT, 32'sd0, 6'd0));
      send_request(make_req(ACT_READ, 32'sd0, 6'd0));
      send_request(make_req(ACT_READ, 32'sd0, 6'd1));
      send_request(make_req(ACT_READ, -32'sd1, 6'd2));
      send_request(make_req(ACT_READ, 32'sd0, 6'd3));
      send_request(make_req(ACT_READ, 32'sd0, 6'd4));
      send_request(make_req(ACT_WRITE, 32'h5555_5555, 6'd1));
      send_request(make_req(ACT_WRITE, 32'hAAAA_AAAA, 6'd3));
      send_request(make_req(ACT_WRITE, 32'sd9, 6'd4));
      send_request(make_req(ACT_READ, 32'sd0, 6'd1));
      send_request(make_req(ACT_READ, 32'sd0, 6'd3));
      send_request(make_req(ACT_POP_FRONT, 32'sd0, 6'd0));
      send_request(make_req(ACT_POP_BACK, 32'sd0, 6'd0));
      send_request(make_req(ACT_READ, 32'sd0, 6'd63));

      // Random phases; the fourth one runs without any idle cycles.
      for (int p = 0; p < 7; p++) begin
         idle_on = (p != 3);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            depth = dq.fill_level();
            roll  = $urandom_range(0, 99);
            act   = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
            case (plan[p])
               MODE_FILL: begin
                  if (roll < 80)
                     act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                  else if (roll < 90)
                     act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
                  else if (roll < 98)
                     act = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
               end
               MODE_DRAIN: begin
                  if (roll < 80)
                     act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
                  else if (roll < 90)
                     act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                  else if (roll < 98)
                     act = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
               end
               default: begin
                  if (roll < 30)
                     act = ACT_READ;
                  else if (roll < 60)
                     act = ACT_WRITE;
                  else if (roll < 78)
                     act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                  else if (roll < 96)
                     act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
               end
            endcase

            // Values lean a little toward the extremes.
            val = $urandom;
            if ($urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 3))
                  0: val = 32'sd0;
                  1: val = -32'sd1;
                  2: val = 32'h8000_0000;
                  default: val = 32'h7FFF_FFFF;
               endcase
            end

            // Positions mostly land inside the list, some on or past its end.
            roll = $urandom_range(0, 99);
            if (roll < 80 && depth > 0)
               pos = 6'($urandom_range(0, depth - 1));
            else if (roll < 90 && depth < CAPACITY)
               pos = 6'(depth);
            else
               pos = 6'($urandom_range(0, 63));

            send_request(make_req(act, val, pos));
         end
      end
      start <= 1'b0;

      // Wait for every owed response, then let the pipeline settle.
      while (dq.pending_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d request beats; responses ok %0d, empty %0d, range %0d, full %0d.",
               beats_sent, dq.status_tally[0], dq.status_tally[1],
               dq.status_tally[2], dq.status_tally[3]);
      $display("Peak occupancy %0d of %0d entries; %0d mismatches.",
               dq.peak_fill, CAPACITY, dq.errors);
      if (dq.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/idq_pkg.sv
rtl/idq_ctrl.sv
rtl/idq_datapath.sv
rtl/indexed_double_ended_queue.sv
verif/tb_indexed_double_ended_queue.sv
